/* rtl/core/jacobi_row_update_ell_core_macros.svh */
// Assertion macros for the row update core and its checker.
`ifndef JACOBI_ROW_UPDATE_ELL_CORE_MACROS_SVH
`define JACOBI_ROW_UPDATE_ELL_CORE_MACROS_SVH

// Check a property with reset masking.
`define JRUE_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jrue assertion failed");

// Check a property at every edge, reset included.
`define JRUE_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("jrue assertion failed");

`endif

/* rtl/core/jrue_pkg.sv */
`timescale 1ns / 1ps
package jrue_pkg;

    localparam int DATA_W    = 32;
    localparam int ACC_W     = 48;
    localparam int ROW_W     = 10;
    localparam int ADDR_W    = 10;
    localparam int COL_W     = 11;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int FRAC_W    = 16;
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_ENTRY = 1'b1;

    typedef struct packed {
        logic accept;
        logic mul;
        logic acc;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic entry;
        logic mac;
        logic row_end;
        logic diag_zero;
    } t_status;

endpackage

/* rtl/core/jacobi_row_update_ell_core.sv */
`timescale 1ns / 1ps
// Jacobi row update over a padded-row sparse matrix, signed Q16.16 data.
// Items with func 0 write one previous-vector element. Items with func 1
// carry one row entry: a diagonal, padding or skipped entry is done once
// accepted, an off-diagonal entry passes through store read, multiply and
// saturating subtract. The closing entry of a row then passes through a
// set-up step, the bit-serial restoring divider that forms the quotient and
// the output register load, which waits for that register to be free; a zero
// diagonal skips the divider. One item is in work at a time, and the output
// register lets the next item enter while a result waits to be taken.
// Previous-vector elements must be written before a row reads them.
module jacobi_row_update_ell_core
    import jrue_pkg::*;
#(
    parameter int VECTOR_DEPTH    = 1024,
    parameter int MAX_ROW_ENTRIES = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_func,
    input  logic [ADDR_W-1:0]        i_vec_addr,
    input  logic signed [DATA_W-1:0] i_vec_value,
    input  logic [ROW_W-1:0]         i_row,
    input  logic signed [COL_W-1:0]  i_column,
    input  logic signed [DATA_W-1:0] i_coeff,
    input  logic signed [DATA_W-1:0] i_rhs,
    input  logic                     i_row_end,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [ROW_W-1:0]         o_row_out,
    output logic signed [DATA_W-1:0] o_x_new,
    output logic                     o_diag_zero
);

    t_cmd    cmd;
    t_status status;

    jrue_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    jrue_dpath #(
        .VECTOR_DEPTH    (VECTOR_DEPTH),
        .MAX_ROW_ENTRIES (MAX_ROW_ENTRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_func      (i_func),
        .i_vec_addr  (i_vec_addr),
        .i_vec_value (i_vec_value),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_coeff     (i_coeff),
        .i_rhs       (i_rhs),
        .i_row_end   (i_row_end),
        .o_row_out   (o_row_out),
        .o_x_new     (o_x_new),
        .o_diag_zero (o_diag_zero)
    );

endmodule

/* rtl/core/jrue_ctrl.sv */
`timescale 1ns / 1ps
module jrue_ctrl
    import jrue_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_FIN,
        S_DIV,
        S_OUT
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic                   r_row_end;
    logic                   n_row_end;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [DIV_CNT_W-1:0]   n_cnt;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic                   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_row_end   = r_row_end;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.accept = 1'b1;
                    n_row_end    = i_status.row_end;
                    if (i_status.entry) begin
                        if (i_status.mac) begin
                            n_state = S_MUL;
                        end else if (i_status.row_end) begin
                            n_state = S_FIN;
                        end
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = r_row_end ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (i_status.diag_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_end   <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_end   <= n_row_end;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/core/jrue_dpath.sv */
`timescale 1ns / 1ps
module jrue_dpath
    import jrue_pkg::*;
#(
    parameter int VECTOR_DEPTH    = 1024,
    parameter int MAX_ROW_ENTRIES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic                    i_func,
    input  logic [ADDR_W-1:0]       i_vec_addr,
    input  logic signed [DATA_W-1:0] i_vec_value,
    input  logic [ROW_W-1:0]        i_row,
    input  logic signed [COL_W-1:0] i_column,
    input  logic signed [DATA_W-1:0] i_coeff,
    input  logic signed [DATA_W-1:0] i_rhs,
    input  logic                    i_row_end,
    output logic [ROW_W-1:0]        o_row_out,
    output logic signed [DATA_W-1:0] o_x_new,
    output logic                    o_diag_zero
);

    localparam int AW    = (VECTOR_DEPTH > 2) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_ROW_ENTRIES + 1);
    localparam int EXT_W = 17;

    logic [DATA_W-1:0]          mem [VECTOR_DEPTH];
    logic [DATA_W-1:0]          r_rdata;

    logic signed [ACC_W-1:0]    r_acc;
    logic signed [DATA_W-1:0]   r_diag;
    logic                       r_in_row;
    logic                       r_pad;
    logic [CNT_W-1:0]           r_cnt;
    logic [ROW_W-1:0]           r_cur_row;
    logic signed [DATA_W-1:0]   r_coeff;
    logic signed [PROD_W-1:0]   r_prod;

    logic [DATA_W-1:0]          r_dm;
    logic [DATA_W-1:0]          r_rem;
    logic [DIV_STEPS-1:0]       r_quo;
    logic                       r_neg;

    logic [ROW_W-1:0]           r_row_out;
    logic [DATA_W-1:0]          r_x_new;
    logic                       r_diag_zero;

    logic                       is_entry;
    logic                       opening;
    logic                       pad_eff;
    logic [CNT_W-1:0]           cnt_eff;
    logic [ROW_W-1:0]           row_eff;
    logic                       active;
    logic                       col_neg;
    logic                       col_diag;
    logic                       col_in_range;
    logic                       wr_in_range;
    logic [EXT_W-1:0]           wr_ext;
    logic [EXT_W-1:0]           rd_ext;
    logic [AW-1:0]              wr_idx;
    logic [AW-1:0]              rd_idx;
    logic                       mem_we;

    logic signed [ACC_W-1:0]    prod_sh;
    logic signed [ACC_W:0]      diff;
    logic signed [ACC_W-1:0]    acc_sat;
    logic [ACC_W-1:0]           acc_mag;
    logic [DATA_W-1:0]          diag_mag;
    logic [DATA_W:0]            rem_sh;
    logic [DATA_W:0]            rem_sub;
    logic                       q_bit;
    logic                       pos_ovf;
    logic                       neg_ovf;
    logic [DATA_W-1:0]          quo_sat;

    assign is_entry     = (i_func == FUNC_ENTRY);
    assign opening      = !r_in_row;
    assign pad_eff      = opening ? 1'b0 : r_pad;
    assign cnt_eff      = opening ? '0 : r_cnt;
    assign row_eff      = opening ? i_row : r_cur_row;
    assign active       = !pad_eff && (cnt_eff < CNT_W'(MAX_ROW_ENTRIES));
    assign col_neg      = i_column[COL_W-1];
    assign col_diag     = !col_neg && (i_column[ROW_W-1:0] == row_eff);
    assign col_in_range = !col_neg
                          && (32'(i_column[ROW_W-1:0]) < 32'(VECTOR_DEPTH));
    assign wr_in_range  = (32'(i_vec_addr) < 32'(VECTOR_DEPTH));
    assign wr_ext       = EXT_W'(i_vec_addr);
    assign rd_ext       = EXT_W'(i_column[ROW_W-1:0]);
    assign wr_idx       = wr_ext[AW-1:0];
    assign rd_idx       = rd_ext[AW-1:0];
    assign mem_we       = i_cmd.accept && !is_entry && wr_in_range;

    assign o_status.entry     = is_entry;
    assign o_status.mac       = is_entry && active && !col_diag && col_in_range;
    assign o_status.row_end   = i_row_end;
    assign o_status.diag_zero = (r_diag == '0);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_idx] <= i_vec_value;
        end
        if (i_cmd.accept) begin
            r_rdata <= mem[rd_idx];
        end
    end

    assign prod_sh = r_prod[PROD_W-1:FRAC_W];
    assign diff    = {r_acc[ACC_W-1], r_acc} - {prod_sh[ACC_W-1], prod_sh};

    always_comb begin
        if (diff[ACC_W] != diff[ACC_W-1]) begin
            acc_sat = diff[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                  : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_sat = diff[ACC_W-1:0];
        end
    end

    assign acc_mag  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign diag_mag = r_diag[DATA_W-1] ? DATA_W'(-r_diag) : DATA_W'(r_diag);
    assign rem_sh   = {r_rem, r_quo[DIV_STEPS-1]};
    assign rem_sub  = rem_sh - {1'b0, r_dm};
    assign q_bit    = (rem_sh >= {1'b0, r_dm});

    assign pos_ovf  = |r_quo[DIV_STEPS-1:DATA_W-1];
    assign neg_ovf  = (|r_quo[DIV_STEPS-1:DATA_W])
                      || (r_quo[DATA_W-1] && (|r_quo[DATA_W-2:0]));

    always_comb begin
        if (!r_neg) begin
            quo_sat = pos_ovf ? {1'b0, {(DATA_W-1){1'b1}}} : r_quo[DATA_W-1:0];
        end else begin
            quo_sat = neg_ovf ? {1'b1, {(DATA_W-1){1'b0}}}
                              : DATA_W'(-r_quo[DATA_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_diag   <= '0;
            r_in_row <= 1'b0;
            r_pad    <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.accept && is_entry) begin
                if (opening) begin
                    r_acc     <= ACC_W'(i_rhs);
                    r_diag    <= '0;
                    r_pad     <= 1'b0;
                    r_cur_row <= i_row;
                end
                if (active) begin
                    if (col_neg) begin
                        r_pad <= 1'b1;
                    end else if (col_diag) begin
                        r_diag <= i_coeff;
                    end
                end
                r_coeff <= i_coeff;
                r_cnt   <= (cnt_eff < CNT_W'(MAX_ROW_ENTRIES)) ? cnt_eff + 1'b1
                                                              : cnt_eff;
                if (i_row_end) begin
                    r_in_row <= 1'b0;
                    r_pad    <= 1'b0;
                    r_cnt    <= '0;
                end else begin
                    r_in_row <= 1'b1;
                end
            end
            if (i_cmd.acc) begin
                r_acc <= acc_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= r_coeff * $signed(r_rdata);
        end
        if (i_cmd.div_start) begin
            r_neg <= r_acc[ACC_W-1] ^ r_diag[DATA_W-1];
            r_dm  <= diag_mag;
            r_rem <= '0;
            r_quo <= {acc_mag, {FRAC_W{1'b0}}};
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            r_quo <= {r_quo[DIV_STEPS-2:0], q_bit};
        end
        if (i_cmd.load_out) begin
            r_row_out   <= r_cur_row;
            r_diag_zero <= (r_diag == '0);
            r_x_new     <= (r_diag == '0) ? '0 : quo_sat;
        end
    end

    assign o_row_out   = r_row_out;
    assign o_x_new     = r_x_new;
    assign o_diag_zero = r_diag_zero;

endmodule

/* rtl/core/jrue_checker.sv */
`timescale 1ns / 1ps
`include "jacobi_row_update_ell_core_macros.svh"
module jrue_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_func,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [9:0]  o_row_out,
    input logic [31:0] o_x_new,
    input logic        o_diag_zero
);

    `JRUE_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid)

    `JRUE_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_x_new) && $stable(o_row_out) && $stable(o_diag_zero))

    `JRUE_ASSERT(a_nan_zero, i_clk, i_rst_n, o_out_valid && o_diag_zero |-> o_x_new == 32'd0)

    `JRUE_ASSERT(a_out_after_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(!o_in_ready))

    `JRUE_ASSERT(a_write_one_cycle, i_clk, i_rst_n, i_in_valid && o_in_ready && !i_func |=> o_in_ready)

endmodule

bind jacobi_row_update_ell_core jrue_checker u_jrue_checker (.*);

/* tb/sv/jacobi_row_update_ell_core_tb.sv */
`timescale 1ns / 1ps
module jacobi_row_update_ell_core_tb;
    import jrue_pkg::*;

    localparam int VEC_DEPTH       = 1024;
    localparam int ROW_ENTRIES     = 16;
    localparam int N_ITEMS         = 900;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int TAIL_CYCLES     = 100;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam longint ACC_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN     = -ACC_MAX - 1;
    localparam logic signed [COL_W-1:0] PAD_COLUMN = -1;

    typedef struct {
        logic                     func;
        logic [ADDR_W-1:0]        vec_addr;
        logic signed [DATA_W-1:0] vec_value;
        logic [ROW_W-1:0]         row;
        logic signed [COL_W-1:0]  column;
        logic signed [DATA_W-1:0] coeff;
        logic signed [DATA_W-1:0] rhs;
        logic                     row_end;
    } t_item;

    typedef struct {
        logic [ROW_W-1:0]         row;
        logic signed [DATA_W-1:0] x;
        logic                     dz;
    } t_row_result;

    typedef struct {
        t_item       item;
        bit          typed;
        t_row_result res;
    } t_dir_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic                     i_func;
    logic [ADDR_W-1:0]        i_vec_addr;
    logic signed [DATA_W-1:0] i_vec_value;
    logic [ROW_W-1:0]         i_row;
    logic signed [COL_W-1:0]  i_column;
    logic signed [DATA_W-1:0] i_coeff;
    logic signed [DATA_W-1:0] i_rhs;
    logic                     i_row_end;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [ROW_W-1:0]         o_row_out;
    logic signed [DATA_W-1:0] o_x_new;
    logic                     o_diag_zero;

    jacobi_row_update_ell_core #(
        .VECTOR_DEPTH   (VEC_DEPTH),
        .MAX_ROW_ENTRIES(ROW_ENTRIES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_vec_addr (i_vec_addr),
        .i_vec_value(i_vec_value),
        .i_row      (i_row),
        .i_column   (i_column),
        .i_coeff    (i_coeff),
        .i_rhs      (i_rhs),
        .i_row_end  (i_row_end),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_row_out  (o_row_out),
        .o_x_new    (o_x_new),
        .o_diag_zero(o_diag_zero)
    );

    // predictor state
    bit signed [DATA_W-1:0] vec_copy [VEC_DEPTH];
    longint                 acc_q32       = 0;
    logic signed [DATA_W-1:0] diag_q16    = '0;
    bit                     row_open      = 1'b0;
    bit                     pad_seen      = 1'b0;
    logic [ROW_W-1:0]       latched_row   = '0;
    int                     entries_taken = 0;

    bit            written [VEC_DEPTH];
    int            written_list[$];
    t_row_result   expected_q[$];
    t_dir_row      dir_tab[$];
    t_row_result   want;
    int            items_sent  = 0;
    int            mismatches  = 0;
    int            idle_cycles = 0;
    bit            no_idle     = 1'b0;
    bit            hold_req    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void predict_row_update(input t_item it, output bit has_res,
                                               output t_row_result res);
        longint      prod;
        logic [63:0] num_mag;
        logic [63:0] den_mag;
        logic [63:0] quot;
        bit          neg;
        has_res = 1'b0;
        res.row = '0;
        res.x   = '0;
        res.dz  = 1'b0;
        if (it.func == FUNC_WRITE) begin
            vec_copy[it.vec_addr] = it.vec_value;
            return;
        end
        if (!row_open) begin
            row_open      = 1'b1;
            acc_q32       = longint'(it.rhs);
            diag_q16      = '0;
            pad_seen      = 1'b0;
            latched_row   = it.row;
            entries_taken = 0;
        end
        if (!pad_seen && entries_taken < ROW_ENTRIES) begin
            if (it.column < 0) begin
                pad_seen = 1'b1;
            end else if (it.column[ADDR_W-1:0] == latched_row) begin
                diag_q16 = it.coeff;
            end else begin
                prod    = longint'(it.coeff) * longint'(vec_copy[it.column[ADDR_W-1:0]]);
                acc_q32 = acc_q32 - (prod >>> FRAC_W);
                if (acc_q32 > ACC_MAX) acc_q32 = ACC_MAX;
                else if (acc_q32 < ACC_MIN) acc_q32 = ACC_MIN;
            end
        end
        if (entries_taken < ROW_ENTRIES) entries_taken++;
        if (!it.row_end) return;
        has_res = 1'b1;
        res.row = latched_row;
        if (diag_q16 == 0) begin
            res.dz = 1'b1;
        end else begin
            num_mag = (acc_q32 < 0) ? -acc_q32 : acc_q32;
            den_mag = (diag_q16 < 0) ? -longint'(diag_q16) : longint'(diag_q16);
            quot    = (num_mag << FRAC_W) / den_mag;
            neg     = (acc_q32 < 0) != (diag_q16 < 0);
            if (!neg) res.x = (quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
            else res.x = (quot > 64'h8000_0000) ? 32'h8000_0000 : -quot[31:0];
        end
        row_open      = 1'b0;
        pad_seen      = 1'b0;
        entries_taken = 0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_q16();
        logic signed [DATA_W-1:0] v;
        v = $urandom_range(0, 32'h0020_0000);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3, 4: return $urandom();
            default: return v - 32'sh0010_0000;
        endcase
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.func      = FUNC_ENTRY;
        it.vec_addr  = ADDR_W'($urandom());
        it.vec_value = $urandom();
        it.row       = ROW_W'($urandom());
        it.column    = PAD_COLUMN;
        it.coeff     = $urandom();
        it.rhs       = $urandom();
        it.row_end   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic void note_written(input int addr);
        if (!written[addr]) begin
            written[addr] = 1'b1;
            written_list.push_back(addr);
        end
    endfunction

    function automatic int pick_written_column();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    task automatic add_write(input int addr, input logic [DATA_W-1:0] value);
        t_dir_row d;
        d.item           = random_item();
        d.item.func      = FUNC_WRITE;
        d.item.vec_addr  = ADDR_W'(addr);
        d.item.vec_value = value;
        d.typed          = 1'b0;
        d.res.row        = '0;
        d.res.x          = '0;
        d.res.dz         = 1'b0;
        note_written(addr);
        dir_tab.push_back(d);
    endtask

    task automatic add_entry(input int row_id, input int col, input logic [DATA_W-1:0] coeff,
                             input logic [DATA_W-1:0] rhs_v, input bit last, input bit typed,
                             input logic [DATA_W-1:0] ex, input bit edz);
        t_dir_row d;
        d.item         = random_item();
        d.item.func    = FUNC_ENTRY;
        d.item.row     = ROW_W'(row_id);
        d.item.column  = COL_W'(col);
        d.item.coeff   = coeff;
        d.item.rhs     = rhs_v;
        d.item.row_end = last;
        d.typed        = typed;
        d.res.row      = ROW_W'(row_id);
        d.res.x        = ex;
        d.res.dz       = edz;
        dir_tab.push_back(d);
    endtask

    task automatic put_item(input t_item it, input bit typed, input t_row_result typed_res);
        bit          has_res;
        t_row_result res;
        int          g;
        g = no_idle ? 0 : pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= it.func;
        i_vec_addr  <= it.vec_addr;
        i_vec_value <= it.vec_value;
        i_row       <= it.row;
        i_column    <= it.column;
        i_coeff     <= it.coeff;
        i_rhs       <= it.rhs;
        i_row_end   <= it.row_end;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_row_update(it, has_res, res);
        if (has_res) expected_q.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    task automatic send_vector_write();
        t_item       it;
        t_row_result no_res;
        no_res.row   = '0;
        no_res.x     = '0;
        no_res.dz    = 1'b0;
        it           = random_item();
        it.func      = FUNC_WRITE;
        it.vec_addr  = ADDR_W'($urandom_range(0, VEC_DEPTH - 1));
        it.vec_value = pick_q16();
        note_written(int'(it.vec_addr));
        put_item(it, 1'b0, no_res);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    // receiver side
    initial begin
        int g;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            g = hold_req ? HOLD_OFF_CYCLES : (no_idle ? 0 : pick_gap());
            hold_req = 1'b0;
            if (g > 0) begin
                i_out_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: row %0d x_new %h diag_zero %0b",
                             o_row_out, o_x_new, o_diag_zero);
            end else begin
                want = expected_q.pop_front();
                if (o_row_out !== want.row || o_x_new !== want.x
                        || o_diag_zero !== want.dz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected row %0d x_new %h diag_zero %0b, %s",
                                 want.row, want.x, want.dz,
                                 $sformatf("got row %0d x_new %h diag_zero %0b",
                                           o_row_out, o_x_new, o_diag_zero));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_item                    it;
        t_row_result              no_res;
        int                       pick;
        int                       k;
        int                       diag_at;
        int                       pad_at;
        logic [ROW_W-1:0]         row_id;
        logic signed [DATA_W-1:0] row_rhs;
        bit                       hold_done;
        bit                       drain_done;
        no_res.row  = '0;
        no_res.x    = '0;
        no_res.dz   = 1'b0;
        hold_done   = 1'b0;
        drain_done  = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_func      = FUNC_WRITE;
        i_vec_addr  = '0;
        i_vec_value = '0;
        i_row       = '0;
        i_column    = '0;
        i_coeff     = '0;
        i_rhs       = '0;
        i_row_end   = 1'b0;

        add_write(0, 32'h0001_0000);
        add_write(1023, 32'h8000_0000);
        add_write(1, 32'h7FFF_FFFF);
        add_write(2, 32'h0002_0000);
        add_entry(5, 5, 32'h0002_0000, 32'h0004_0000, 1'b0, 1'b0, 0, 1'b0);
        add_entry(5, 0, 32'h0001_0000, 32'h0004_0000, 1'b1, 1'b1, 32'h0001_8000, 1'b0);
        // diagonal absent, then diagonal present but zero
        add_entry(7, 0, 32'h0001_0000, 32'h8000_0000, 1'b1, 1'b1, 0, 1'b1);
        add_entry(3, 3, 32'h0000_0000, 32'h0001_0000, 1'b1, 1'b1, 0, 1'b1);
        // everything after padding is dropped
        add_entry(1023, 1023, 32'h0001_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 0, 1'b0);
        add_entry(1023, -1, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 0, 1'b0);
        add_entry(1023, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 0, 1'b0);
        add_entry(1023, 1023, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0);
        // repeated diagonal: last one before padding holds
        add_entry(10, 10, 32'h0002_0000, 32'h0003_0000, 1'b0, 1'b0, 0, 1'b0);
        add_entry(10, 10, 32'h0001_0000, 32'h0003_0000, 1'b0, 1'b0, 0, 1'b0);
        add_entry(10, -1, 32'h0001_0000, 32'h0003_0000, 1'b0, 1'b0, 0, 1'b0);
        add_entry(10, 10, 32'h0004_0000, 32'h0003_0000, 1'b1, 1'b1, 32'h0003_0000, 1'b0);
        // accumulator and quotient saturation, both signs
        add_entry(0, 0, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 0, 1'b0);
        add_entry(0, 1023, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 0, 1'b0);
        add_entry(0, 1023, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 0, 1'b0);
        add_entry(0, 1023, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0);
        add_entry(1, 1, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 0, 1'b0);
        add_entry(1, 1023, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 0, 1'b0);
        add_entry(1, 1023, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 0, 1'b0);
        add_entry(1, 1023, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) put_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);

        while (items_sent < N_ITEMS) begin
            if (!hold_done && items_sent >= 300) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && items_sent >= 600) begin
                wait_drained();
                drain_done = 1'b1;
            end
            no_idle = (items_sent >= 450 && items_sent < 530);
            pick    = $urandom_range(0, 99);
            if (pick < 15) begin
                repeat ($urandom_range(1, 4)) send_vector_write();
            end else begin
                row_id  = ROW_W'($urandom());
                row_rhs = pick_q16();
                k       = (pick < 22) ? $urandom_range(ROW_ENTRIES - 1, ROW_ENTRIES + 3)
                                      : $urandom_range(1, 6);
                diag_at = $urandom_range(0, k);
                pad_at  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, k) : k;
                for (int j = 0; j < k; j++) begin
                    if (pick >= 95 && $urandom_range(0, 2) == 0) send_vector_write();
                    it      = random_item();
                    it.func = FUNC_ENTRY;
                    if (pick >= 90 && j > 0 && $urandom_range(0, 1) == 0)
                        it.row = ROW_W'($urandom());
                    else
                        it.row = row_id;
                    if (j == 0) it.rhs = row_rhs;
                    if (j == pad_at || (j > pad_at && $urandom_range(0, 1) == 0))
                        it.column = PAD_COLUMN;
                    else if (j == diag_at || $urandom_range(0, 9) == 0)
                        it.column = COL_W'(row_id);
                    else
                        it.column = COL_W'(pick_written_column());
                    it.coeff   = pick_q16();
                    it.row_end = (j == k - 1);
                    put_item(it, 1'b0, no_res);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
